/* hdl/skya_pkg.sv */
// shared types and constants for the skyline atlas allocator
// depends on nothing; every other file but skya_ram imports it
package skya_pkg;

    // default geometry of one atlas page and the page budget
    localparam int PAGE_WIDTH_DEF  = 256;
    localparam int PAGE_HEIGHT_DEF = 256;
    localparam int PAGES_DEF       = 256;

    // one request beat
    typedef struct packed {
        logic [8:0] req_width;
        logic [8:0] req_height;
    } req_t;

    // one result beat
    typedef struct packed {
        logic       ok;
        logic [7:0] page;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       new_page;
    } res_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic fwd_start;
        logic fwd_step;
        logic bwd_start;
        logic bwd_step;
        logic new_page;
        logic wr_start;
        logic wr_step;
        logic res_load;
        logic res_ok;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic bad_size;
        logic no_page_open;
        logic idx_last;
        logic idx_first;
        logic fit;
        logic pages_full;
        logic wr_last;
    } sts_t;

endpackage

/* hdl/skyline_atlas_allocator.sv */
// Skyline atlas allocator: places one width x height rectangle per request on the current
// atlas page and answers with ok, page, pos_x, pos_y and new_page. A request refused for
// size goes straight to its result. One with no page open opens a page; any other makes
// two passes over the column-height ram, one column read per cycle, then opens a fresh page
// if it has to and the budget allows. Each placed rectangle is written one column per cycle.
// One request is worked at a time; a new one is taken while the last result waits in the
// output register. No clearing pass is needed after reset: a fill count marks the columns
// written on the open page, and columns past it read as empty.
// top level: joins skya_ctrl and skya_dp; depends on skya_pkg
module skyline_atlas_allocator #(
    parameter int PAGE_WIDTH  = skya_pkg::PAGE_WIDTH_DEF,
    parameter int PAGE_HEIGHT = skya_pkg::PAGE_HEIGHT_DEF,
    parameter int PAGES       = skya_pkg::PAGES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  skya_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output skya_pkg::res_t out_data
);
    import skya_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    skya_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // skyline storage and search
    skya_dp #(
        .PAGE_WIDTH  (PAGE_WIDTH),
        .PAGE_HEIGHT (PAGE_HEIGHT),
        .PAGES       (PAGES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

/* hdl/skya_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// depends on nothing
module skya_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/skya_dp.sv */
// datapath: skyline column ram, block-max scratch ram, window search and result register
// depends on skya_pkg and skya_ram
module skya_dp #(
    parameter int PAGE_WIDTH  = skya_pkg::PAGE_WIDTH_DEF,
    parameter int PAGE_HEIGHT = skya_pkg::PAGE_HEIGHT_DEF,
    parameter int PAGES       = skya_pkg::PAGES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  skya_pkg::req_t in_data,
    input  skya_pkg::cmd_t cmd,
    output skya_pkg::sts_t sts,
    output skya_pkg::res_t out_data
);
    import skya_pkg::*;

    localparam int AW   = $clog2(PAGE_WIDTH);
    localparam int CH_W = $clog2(PAGE_HEIGHT + 1);
    localparam int EW   = AW + 2;
    localparam int FW   = ((CH_W > 9) ? CH_W : 9) + 1;
    localparam int PU_W = ($clog2(PAGES + 1) > 1) ? $clog2(PAGES + 1) : 1;

    localparam logic [AW-1:0]   IDX_MAX = AW'(PAGE_WIDTH - 1);
    localparam logic [CH_W-1:0] PH      = CH_W'(PAGE_HEIGHT);

    req_t            req_reg,   req_next;
    logic            fresh_reg, fresh_next;
    logic [AW-1:0]   idx_reg,   idx_next;
    logic [AW-1:0]   off_reg,   off_next;
    logic [AW:0]     rem_reg,   rem_next;
    logic [AW:0]     fill_reg,  fill_next;
    logic [PU_W-1:0] pages_reg, pages_next;
    logic [CH_W-1:0] best_reg,  best_next;
    logic [AW-1:0]   bestx_reg, bestx_next;
    logic [CH_W-1:0] run_reg,   run_next;
    logic            fvld_reg,  fvld_next;
    logic            bvld_reg,  bvld_next;
    logic            rst_d_reg, rst_d_next;
    logic [AW-1:0]   idxd_reg,  idxd_next;
    logic            win_reg,   win_next;
    res_t            res_reg,   res_next;

    logic [AW-1:0]   wm1;
    logic [EW-1:0]   tail;
    logic [EW-1:0]   span_end;
    logic            win_now;
    logic [CH_W-1:0] col_rd;
    logic [CH_W-1:0] aux_rd;
    logic [CH_W-1:0] col_val;
    logic [CH_W-1:0] run_new;
    logic [CH_W-1:0] win_max;
    logic [CH_W-1:0] raise;

    // column heights; entries at or beyond the fill count read as empty
    skya_ram #(.WIDTH(CH_W), .DEPTH(PAGE_WIDTH)) u_col_ram (
        .clk   (clk),
        .we    (cmd.wr_step),
        .waddr (idx_reg),
        .wdata (raise),
        .raddr (idx_reg),
        .rdata (col_rd)
    );

    // prefix maxima inside each block of req_width columns
    skya_ram #(.WIDTH(CH_W), .DEPTH(PAGE_WIDTH)) u_aux_ram (
        .clk   (clk),
        .we    (fvld_reg),
        .waddr (idxd_reg),
        .wdata (run_new),
        .raddr (tail[AW-1:0]),
        .rdata (aux_rd)
    );

    // window geometry on the issue side
    always_comb
    begin
        wm1      = AW'(req_reg.req_width - 9'd1);
        tail     = EW'(idx_reg) + EW'(req_reg.req_width) - EW'(1);
        win_now  = (tail < EW'(PAGE_WIDTH));
        span_end = EW'(bestx_reg) + EW'(req_reg.req_width);
        raise    = CH_W'(FW'(best_reg) + FW'(req_reg.req_height));
    end

    // read stage: running block max and window max
    always_comb
    begin
        col_val = ((AW + 1)'(idxd_reg) < fill_reg) ? col_rd : '0;
        if (rst_d_reg)
        begin
            run_new = col_val;
        end
        else
        begin
            run_new = (col_val > run_reg) ? col_val : run_reg;
        end
        win_max = (run_new > aux_rd) ? run_new : aux_rd;
    end

    // status to the controller
    always_comb
    begin
        sts.bad_size     = (req_reg.req_width == 9'd0) || (req_reg.req_height == 9'd0) ||
                           (32'(req_reg.req_width) > 32'(PAGE_WIDTH)) ||
                           (32'(req_reg.req_height) > 32'(PAGE_HEIGHT));
        sts.no_page_open = (pages_reg == '0);
        sts.idx_last     = (idx_reg == IDX_MAX);
        sts.idx_first    = (idx_reg == '0);
        sts.fit          = (FW'(best_reg) + FW'(req_reg.req_height) <= FW'(PAGE_HEIGHT));
        sts.pages_full   = (32'(pages_reg) >= 32'(PAGES));
        sts.wr_last      = (rem_reg == (AW + 1)'(1));
    end

    // next-state logic for the datapath registers
    always_comb
    begin
        req_next   = req_reg;
        fresh_next = fresh_reg;
        idx_next   = idx_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        fill_next  = fill_reg;
        pages_next = pages_reg;
        best_next  = best_reg;
        bestx_next = bestx_reg;
        run_next   = run_reg;
        res_next   = res_reg;
        fvld_next  = cmd.fwd_step;
        bvld_next  = cmd.bwd_step;
        idxd_next  = idx_reg;
        win_next   = win_now;
        if (cmd.fwd_step)
        begin
            rst_d_next = (off_reg == '0);
        end
        else
        begin
            rst_d_next = (idx_reg == IDX_MAX) || (off_reg == wm1);
        end

        if (cmd.load)
        begin
            req_next   = in_data;
            fresh_next = 1'b0;
        end

        // forward pass: ascending, blocks start where the offset is zero
        if (cmd.fwd_start)
        begin
            idx_next = '0;
            off_next = '0;
        end
        if (cmd.fwd_step)
        begin
            idx_next = AW'(idx_reg + 1'b1);
            off_next = (off_reg == wm1) ? '0 : AW'(off_reg + 1'b1);
        end

        // backward pass: descending, same block partition
        if (cmd.bwd_start)
        begin
            idx_next   = IDX_MAX;
            off_next   = (off_reg == '0) ? wm1 : AW'(off_reg - 1'b1);
            best_next  = PH;
            bestx_next = '0;
        end
        if (cmd.bwd_step)
        begin
            idx_next = AW'(idx_reg - 1'b1);
            off_next = (off_reg == '0) ? wm1 : AW'(off_reg - 1'b1);
        end

        if (fvld_reg || bvld_reg)
        begin
            run_next = run_new;
        end
        // right to left, so ties move the pick leftward
        if (bvld_reg && win_reg && (win_max < PH) && (win_max <= best_reg))
        begin
            best_next  = win_max;
            bestx_next = idxd_reg;
        end

        // write-back setup on the current page
        if (cmd.wr_start)
        begin
            idx_next = bestx_reg;
            rem_next = (AW + 1)'(req_reg.req_width);
            if (span_end > EW'(fill_reg))
            begin
                fill_next = (AW + 1)'(span_end);
            end
        end

        // fresh page: skyline empties, rectangle goes to the left edge
        if (cmd.new_page)
        begin
            pages_next = PU_W'(pages_reg + 1'b1);
            fill_next  = (AW + 1)'(req_reg.req_width);
            best_next  = '0;
            bestx_next = '0;
            fresh_next = 1'b1;
            idx_next   = '0;
            rem_next   = (AW + 1)'(req_reg.req_width);
        end

        if (cmd.wr_step)
        begin
            idx_next = AW'(idx_reg + 1'b1);
            rem_next = (AW + 1)'(rem_reg - 1'b1);
        end

        // result register
        if (cmd.res_load)
        begin
            if (cmd.res_ok)
            begin
                res_next.ok       = 1'b1;
                res_next.page     = 8'(pages_reg - 1'b1);
                res_next.pos_x    = 8'(bestx_reg);
                res_next.pos_y    = 8'(best_reg);
                res_next.new_page = fresh_reg;
            end
            else
            begin
                res_next = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= '0;
            fill_reg  <= '0;
            fvld_reg  <= 1'b0;
            bvld_reg  <= 1'b0;
        end
        else
        begin
            pages_reg <= pages_next;
            fill_reg  <= fill_next;
            fvld_reg  <= fvld_next;
            bvld_reg  <= bvld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        fresh_reg <= fresh_next;
        idx_reg   <= idx_next;
        off_reg   <= off_next;
        rem_reg   <= rem_next;
        best_reg  <= best_next;
        bestx_reg <= bestx_next;
        run_reg   <= run_next;
        rst_d_reg <= rst_d_next;
        idxd_reg  <= idxd_next;
        win_reg   <= win_next;
        res_reg   <= res_next;
    end

    assign out_data = res_reg;

endmodule

/* hdl/skya_ctrl.sv */
// controller: sequences size check, two skyline passes, page open and write-back
// depends on skya_pkg
module skya_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  skya_pkg::sts_t sts,
    output skya_pkg::cmd_t cmd
);
    import skya_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FWD,
        S_FDRAIN,
        S_BWD,
        S_BDRAIN,
        S_DECIDE,
        S_NEWPG,
        S_WRITE,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   ok_reg,    ok_next;
    logic   ovld_reg,  ovld_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        ovld_next  = ovld_reg && !out_ready;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.bad_size)
                begin
                    ok_next    = 1'b0;
                    state_next = S_RESULT;
                end
                else if (sts.no_page_open)
                begin
                    state_next = S_NEWPG;
                end
                else
                begin
                    cmd.fwd_start = 1'b1;
                    state_next    = S_FWD;
                end
            end
            S_FWD:
            begin
                cmd.fwd_step = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_FDRAIN;
                end
            end
            S_FDRAIN:
            begin
                cmd.bwd_start = 1'b1;
                state_next    = S_BWD;
            end
            S_BWD:
            begin
                cmd.bwd_step = 1'b1;
                if (sts.idx_first)
                begin
                    state_next = S_BDRAIN;
                end
            end
            S_BDRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.fit)
                begin
                    cmd.wr_start = 1'b1;
                    state_next   = S_WRITE;
                end
                else if (sts.pages_full)
                begin
                    ok_next    = 1'b0;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_NEWPG;
                end
            end
            S_NEWPG:
            begin
                cmd.new_page = 1'b1;
                state_next   = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_step = 1'b1;
                if (sts.wr_last)
                begin
                    ok_next    = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!ovld_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_ok   = ok_reg;
                    ovld_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ok_reg    <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            ovld_reg  <= ovld_next;
        end
    end

    assign out_valid = ovld_reg;

endmodule

/* hdl/skya_chk.sv */
// port-level checks for the skyline atlas allocator, bound to the top level
// depends on skya_pkg and skyline_atlas_allocator
module skya_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input skya_pkg::res_t out_data
);
    import skya_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // a refused request carries all-zero fields
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |->
            out_data.page == 8'd0 && out_data.pos_x == 8'd0 &&
            out_data.pos_y == 8'd0 && !out_data.new_page)
        else $error("refused result with nonzero fields");

    // a fresh page always takes the rectangle at its origin
    a_fresh_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.new_page |->
            out_data.ok && out_data.pos_x == 8'd0 && out_data.pos_y == 8'd0)
        else $error("new page result not at origin");

    // one request in flight: no request taken right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in work");

endmodule

bind skyline_atlas_allocator skya_chk u_skya_chk (.*);
